[design/bllc_pkg.sv]
// ----------------------------------------------------------------------------
// bllc_pkg
// shared widths, request codes, status codes and register indexes of the
// dual list lru block cache
// ----------------------------------------------------------------------------
package bllc_pkg;

  localparam int ENTRIES_DEF    = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int FUNC_W     = 2;
  localparam int HANDLE_W   = 48;
  localparam int SIZE_W     = 40;
  localparam int USED_W     = 41;
  localparam int UCNT_W     = 16;
  localparam int STAT_W     = 3;
  localparam int FACTOR_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_EVICT   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR   = 2'd1;

endpackage

[design/bllc_ram.sv]
// ----------------------------------------------------------------------------
// bllc_ram
// single port write, single port read synchronous memory, registered read
// ----------------------------------------------------------------------------
module bllc_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/dual_list_lru_block_cache.sv]
// ----------------------------------------------------------------------------
// dual_list_lru_block_cache
// block table on two recency lists with reference counts, lru eviction
//
// channel  | direction | handshake                 | payload
// request  | in        | start_i && !busy_o        | func, handle, size, write_mode
// result   | out       | res_valid_o, one cycle    | status .. last
// config   | in        | cfg_valid_i && cfg_ready_o| cfg_index_i, cfg_data_i
//
// lookup walks the entry memory one entry a cycle to find or miss, then decodes,
// does the link read-modify-write and writes back, and the result is registered
// onto the ports in the cycle after S_FIN.
// evict walks the lists, skipping busy blocks and unlinking each freed block,
// then emits one result a cycle from the result buffer.
// no clearing pass after reset, valid bits and list pointers reset at once.
// results cannot be stalled; busy_o holds off new transactions.
// ----------------------------------------------------------------------------
module dual_list_lru_block_cache #(
  parameter int ENTRIES    = bllc_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = bllc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [bllc_pkg::FUNC_W-1:0]         func_i,
  input  logic [bllc_pkg::HANDLE_W-1:0]       handle_i,
  input  logic [bllc_pkg::SIZE_W-1:0]         size_i,
  input  logic                                write_mode_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bllc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bllc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                res_valid_o,
  output logic [bllc_pkg::STAT_W-1:0]         status_o,
  output logic [bllc_pkg::HANDLE_W-1:0]       block_handle_o,
  output logic [bllc_pkg::SIZE_W-1:0]         block_size_o,
  output logic                                needs_writeback_o,
  output logic                                reuse_o,
  output logic [bllc_pkg::UCNT_W-1:0]         use_count_o,
  output logic                                would_be_full_o,
  output logic [bllc_pkg::USED_W-1:0]         used_bytes_o,
  output logic                                last_o
);
  import bllc_pkg::*;

  localparam int IW   = $clog2(ENTRIES);
  localparam int KW   = IW + 1;
  localparam int PW   = IW + 1;
  localparam int CB   = COUNT_BITS;
  localparam int DW   = HANDLE_W + SIZE_W + 1 + 2 * CB;
  localparam int LW   = 2 * PW;
  localparam int RW   = HANDLE_W + SIZE_W + 2;
  localparam int FW   = SIZE_W + IW + 1;
  localparam int TW   = SIZE_W + FACTOR_W;
  localparam int CMPW = (FW > TW) ? FW : TW;
  localparam logic [PW-1:0] NIL     = {PW{1'b1}};
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
  localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOOK   = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_LNKL   = 4'd3;
  localparam logic [3:0] S_UL_P   = 4'd4;
  localparam logic [3:0] S_UL_N   = 4'd5;
  localparam logic [3:0] S_LRD    = 4'd6;
  localparam logic [3:0] S_LWR    = 4'd7;
  localparam logic [3:0] S_AP     = 4'd8;
  localparam logic [3:0] S_DWR    = 4'd9;
  localparam logic [3:0] S_EV_HD  = 4'd10;
  localparam logic [3:0] S_EV_CHK = 4'd11;
  localparam logic [3:0] S_EV_NX  = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;
  localparam logic [3:0] S_EMIT   = 4'd14;

  function automatic logic [USED_W-1:0] sat_sub(logic [USED_W-1:0] a, logic [SIZE_W-1:0] b);
    logic [USED_W-1:0] bx;
    bx = USED_W'(b);
    return (a < bx) ? '0 : a - bx;
  endfunction

  function automatic logic [USED_W-1:0] sat_add(logic [USED_W-1:0] a, logic [SIZE_W-1:0] b);
    logic [USED_W:0] s;
    s = {1'b0, a} + (USED_W + 1)'(b);
    return s[USED_W] ? USED_MAX : s[USED_W-1:0];
  endfunction

  // control state
  logic [3:0] state_q, state_d, ret_q, ret_d, cont_q, cont_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [PW-1:0] head_q [2];
  logic [PW-1:0] head_d [2];
  logic [PW-1:0] tail_q [2];
  logic [PW-1:0] tail_d [2];
  logic [USED_W-1:0] used_q, used_d;
  logic [SIZE_W-1:0] cap_q;
  logic [FACTOR_W-1:0] factor_q;
  logic res_valid_q, res_valid_d;
  logic pend_q, pend_d;

  // request and working registers
  logic [FUNC_W-1:0] func_q, func_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic wm_q, wm_d;
  logic [TW-1:0] thr_q, thr_d;
  logic [KW-1:0] k_q, k_d, rn_q, rn_d, e_q, e_d;
  logic [IW-1:0] rdk_q, rdk_d, slot_q, slot_d, free_q, free_d;
  logic found_q, found_d, free_ok_q, free_ok_d;
  logic [HANDLE_W-1:0] dh_q, dh_d;
  logic [SIZE_W-1:0] ds_q, ds_d;
  logic dw_q, dw_d;
  logic [CB-1:0] drc_q, drc_d, dwc_q, dwc_d;
  logic l_q, l_d;
  logic [PW-1:0] p_q, p_d, n_q, n_d, cur_q, cur_d, la_q, la_d, lv_q, lv_d;
  logic lsel_q, lsel_d;
  logic [FW-1:0] freed_q, freed_d;
  logic reused_q, reused_d, stop_q, stop_d, full_q, full_d;
  logic [STAT_W-1:0] st_q, st_d;
  logic [UCNT_W-1:0] ucnt_q, ucnt_d;

  // result registers
  logic [STAT_W-1:0] o_st_q, o_st_d;
  logic [HANDLE_W-1:0] o_bh_q, o_bh_d;
  logic [SIZE_W-1:0] o_bs_q, o_bs_d;
  logic o_wb_q, o_wb_d, o_ru_q, o_ru_d, o_full_q, o_full_d, o_last_q, o_last_d;
  logic [UCNT_W-1:0] o_uc_q, o_uc_d;
  logic [USED_W-1:0] o_used_q, o_used_d;

  // memory ports
  logic dm_we, lm_we, rb_we;
  logic [IW-1:0] dm_wa, dm_ra, lm_wa, lm_ra, rb_wa, rb_ra;
  logic [DW-1:0] dm_wd, dm_rd;
  logic [LW-1:0] lm_wd, lm_rd;
  logic [RW-1:0] rb_wd, rb_rd;

  logic [HANDLE_W-1:0] do_h;
  logic [SIZE_W-1:0] do_s;
  logic [CB-1:0] do_rc, do_wc;
  logic [PW-1:0] lo_p, lo_n;

  assign do_h  = dm_rd[DW-1 -: HANDLE_W];
  assign do_s  = dm_rd[2*CB+1 +: SIZE_W];
  assign do_rc = dm_rd[CB +: CB];
  assign do_wc = dm_rd[0 +: CB];
  assign lo_p  = lm_rd[PW +: PW];
  assign lo_n  = lm_rd[0 +: PW];

  bllc_ram #(.W(DW), .D(ENTRIES)) u_data (
    .clk_i(clk_i), .we_i(dm_we), .waddr_i(dm_wa), .wdata_i(dm_wd),
    .raddr_i(dm_ra), .rdata_o(dm_rd)
  );

  bllc_ram #(.W(LW), .D(ENTRIES)) u_link (
    .clk_i(clk_i), .we_i(lm_we), .waddr_i(lm_wa), .wdata_i(lm_wd),
    .raddr_i(lm_ra), .rdata_o(lm_rd)
  );

  bllc_ram #(.W(RW), .D(ENTRIES)) u_resbuf (
    .clk_i(clk_i), .we_i(rb_we), .waddr_i(rb_wa), .wdata_i(rb_wd),
    .raddr_i(rb_ra), .rdata_o(rb_rd)
  );

  always_comb begin
    logic [CB-1:0] cnt;
    logic [CB-1:0] ncnt;
    logic ru;
    logic [FW-1:0] fsum;
    logic [PW-1:0] t;
    logic [SIZE_W:0] usum;
    logic scan_end;

    state_d = state_q; ret_d = ret_q; cont_d = cont_q;
    valid_d = valid_q;
    head_d = head_q; tail_d = tail_q;
    used_d = used_q;
    res_valid_d = 1'b0; pend_d = 1'b0;
    func_d = func_q; handle_d = handle_q; size_d = size_q; wm_d = wm_q; thr_d = thr_q;
    k_d = k_q; rn_d = rn_q; e_d = e_q; rdk_d = rdk_q; slot_d = slot_q; free_d = free_q;
    found_d = found_q; free_ok_d = free_ok_q;
    dh_d = dh_q; ds_d = ds_q; dw_d = dw_q; drc_d = drc_q; dwc_d = dwc_q;
    l_d = l_q; p_d = p_q; n_d = n_q; cur_d = cur_q; la_d = la_q; lv_d = lv_q;
    lsel_d = lsel_q; freed_d = freed_q; reused_d = reused_q; stop_d = stop_q;
    full_d = full_q; st_d = st_q; ucnt_d = ucnt_q;
    o_st_d = o_st_q; o_bh_d = o_bh_q; o_bs_d = o_bs_q; o_wb_d = o_wb_q; o_ru_d = o_ru_q;
    o_full_d = o_full_q; o_last_d = o_last_q; o_uc_d = o_uc_q; o_used_d = o_used_q;
    dm_we = 1'b0; dm_wa = slot_q; dm_wd = {dh_q, ds_q, dw_q, drc_q, dwc_q};
    dm_ra = k_q[IW-1:0];
    lm_we = 1'b0; lm_wa = la_q[IW-1:0]; lm_wd = '0; lm_ra = slot_q;
    rb_we = 1'b0; rb_wa = rn_q[IW-1:0]; rb_wd = '0; rb_ra = e_q[IW-1:0];
    cnt = wm_q ? dwc_q : drc_q;
    ncnt = cnt;
    ru = 1'b0;
    fsum = freed_q + FW'(do_s);
    t = tail_q[wm_q];
    usum = {1'b0, size_q};
    scan_end = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d = func_i; handle_d = handle_i; size_d = size_i; wm_d = write_mode_i;
          thr_d = TW'(size_i) * TW'(factor_q);
          rn_d = '0; freed_d = '0; reused_d = 1'b0; l_d = 1'b0;
          found_d = 1'b0; free_ok_d = 1'b0; k_d = '0;
          st_d = ST_OK; ucnt_d = '0;
          state_d = (func_i == FUNC_EVICT) ? S_EV_HD : S_LOOK;
        end
      end
      S_LOOK: begin
        dm_ra = k_q[IW-1:0];
        if (k_q < KW'(ENTRIES)) begin
          k_d = k_q + 1'b1;
          pend_d = 1'b1;
          rdk_d = k_q[IW-1:0];
        end
        if (pend_q) begin
          if (valid_q[rdk_q] && do_h == handle_q) begin
            found_d = 1'b1; slot_d = rdk_q;
            dh_d = do_h; ds_d = do_s; dw_d = dm_rd[2*CB]; drc_d = do_rc; dwc_d = do_wc;
            state_d = S_PREP;
          end else begin
            if (!valid_q[rdk_q] && !free_ok_q) begin
              free_ok_d = 1'b1; free_d = rdk_q;
            end
            if (rdk_q == IW'(ENTRIES - 1)) state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        lm_ra = slot_q;
        if (func_q == FUNC_INSERT) begin
          dh_d = handle_q; ds_d = size_q;
          drc_d = wm_q ? '0 : CB'(1); dwc_d = wm_q ? CB'(1) : '0;
          if (found_q) begin
            used_d = sat_sub(used_q, ds_q);
            l_d = dw_q; cont_d = S_AP; state_d = S_LNKL;
          end else if (free_ok_q) begin
            slot_d = free_q; state_d = S_AP;
          end else begin
            st_d = ST_FULL; state_d = S_FIN;
          end
        end else if (!found_q) begin
          st_d = ST_NOT_FOUND; state_d = S_FIN;
        end else if (func_q == FUNC_ACQUIRE) begin
          ncnt = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
          if (wm_q) dwc_d = ncnt; else drc_d = ncnt;
          ucnt_d = UCNT_W'(ncnt);
          l_d = dw_q; cont_d = S_AP; state_d = S_LNKL;
        end else if (cnt == '0) begin
          st_d = ST_UNDERFLOW; state_d = S_FIN;
        end else begin
          ncnt = cnt - 1'b1;
          if (wm_q) dwc_d = ncnt; else drc_d = ncnt;
          ucnt_d = UCNT_W'(ncnt);
          state_d = S_DWR;
        end
      end
      S_LNKL: begin
        p_d = lo_p; n_d = lo_n;
        if (func_q == FUNC_INSERT || l_q != wm_q || !lo_n[PW-1]) state_d = S_UL_P;
        else state_d = S_DWR;
      end
      S_UL_P: begin
        if (p_q[PW-1]) begin
          head_d[l_q] = n_q; state_d = S_UL_N;
        end else begin
          la_d = p_q; lsel_d = 1'b1; lv_d = n_q; ret_d = S_UL_N; state_d = S_LRD;
        end
      end
      S_UL_N: begin
        if (n_q[PW-1]) begin
          tail_d[l_q] = p_q; state_d = cont_q;
        end else begin
          la_d = n_q; lsel_d = 1'b0; lv_d = p_q; ret_d = cont_q; state_d = S_LRD;
        end
      end
      S_LRD: begin
        lm_ra = la_q[IW-1:0];
        state_d = S_LWR;
      end
      S_LWR: begin
        lm_we = 1'b1; lm_wa = la_q[IW-1:0];
        lm_wd = lsel_q ? {lo_p, lv_q} : {lv_q, lo_n};
        state_d = ret_q;
      end
      S_AP: begin
        lm_we = 1'b1; lm_wa = slot_q; lm_wd = {t, NIL};
        tail_d[wm_q] = {1'b0, slot_q};
        dw_d = wm_q;
        if (t[PW-1]) begin
          head_d[wm_q] = {1'b0, slot_q}; state_d = S_DWR;
        end else begin
          la_d = t; lsel_d = 1'b1; lv_d = {1'b0, slot_q}; ret_d = S_DWR; state_d = S_LRD;
        end
      end
      S_DWR: begin
        dm_we = 1'b1;
        valid_d[slot_q] = 1'b1;
        if (func_q == FUNC_INSERT) used_d = sat_add(used_q, size_q);
        state_d = S_FIN;
      end
      S_EV_HD: begin
        dm_ra = head_q[l_q][IW-1:0]; lm_ra = head_q[l_q][IW-1:0];
        if (head_q[l_q][PW-1]) scan_end = 1'b1;
        else begin
          cur_d = head_q[l_q]; state_d = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        dm_ra = lo_n[IW-1:0]; lm_ra = lo_n[IW-1:0];
        if (do_rc != '0 || do_wc != '0) begin
          if (lo_n[PW-1]) scan_end = 1'b1;
          else cur_d = lo_n;
        end else begin
          valid_d[cur_q[IW-1:0]] = 1'b0;
          ru = !reused_q && (do_s >= size_q);
          rb_we = 1'b1; rb_wd = {do_h, do_s, l_q, ru};
          rn_d = rn_q + 1'b1;
          reused_d = reused_q | ru;
          freed_d = fsum;
          used_d = sat_sub(used_q, do_s);
          stop_d = CMPW'(fsum) >= CMPW'(thr_q);
          p_d = lo_p; n_d = lo_n; cont_d = S_EV_NX; state_d = S_UL_P;
        end
      end
      S_EV_NX: begin
        dm_ra = n_q[IW-1:0]; lm_ra = n_q[IW-1:0];
        if (stop_q || n_q[PW-1]) scan_end = 1'b1;
        else begin
          cur_d = n_q; state_d = S_EV_CHK;
        end
      end
      S_FIN: begin
        usum = {1'b0, cap_q};
        full_d = ({1'b0, used_q} + (USED_W + 1)'(size_q)) >= (USED_W + 1)'(usum);
        if (func_q == FUNC_EVICT && rn_q != '0) begin
          rb_ra = '0; e_d = KW'(1); state_d = S_EMIT;
        end else begin
          res_valid_d = 1'b1;
          o_st_d = (func_q == FUNC_EVICT) ? ST_NONE : st_q;
          o_bh_d = '0; o_bs_d = '0; o_wb_d = 1'b0; o_ru_d = 1'b0;
          o_uc_d = ucnt_q; o_full_d = full_d; o_used_d = used_q; o_last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        res_valid_d = 1'b1;
        o_st_d = ST_OK;
        o_bh_d = rb_rd[RW-1 -: HANDLE_W];
        o_bs_d = rb_rd[2 +: SIZE_W];
        o_wb_d = rb_rd[1]; o_ru_d = rb_rd[0];
        o_uc_d = '0; o_full_d = full_q; o_used_d = used_q;
        o_last_d = (e_q == rn_q);
        rb_ra = e_q[IW-1:0];
        e_d = e_q + 1'b1;
        if (e_q == rn_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (scan_end) begin
      if (!l_q && !reused_q) begin
        l_d = 1'b1; freed_d = '0; state_d = S_EV_HD;
      end else begin
        state_d = S_FIN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      head_q <= '{NIL, NIL};
      tail_q <= '{NIL, NIL};
      used_q <= '0;
      cap_q <= '0;
      factor_q <= FACTOR_W'(1);
      res_valid_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      head_q <= head_d;
      tail_q <= tail_d;
      used_q <= used_d;
      res_valid_q <= res_valid_d;
      pend_q <= pend_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_CAPACITY) cap_q <= cfg_data_i[SIZE_W-1:0];
        else if (cfg_index_i == CFG_FACTOR) factor_q <= cfg_data_i[FACTOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; cont_q <= cont_d;
    func_q <= func_d; handle_q <= handle_d; size_q <= size_d; wm_q <= wm_d; thr_q <= thr_d;
    k_q <= k_d; rn_q <= rn_d; e_q <= e_d; rdk_q <= rdk_d; slot_q <= slot_d; free_q <= free_d;
    found_q <= found_d; free_ok_q <= free_ok_d;
    dh_q <= dh_d; ds_q <= ds_d; dw_q <= dw_d; drc_q <= drc_d; dwc_q <= dwc_d;
    l_q <= l_d; p_q <= p_d; n_q <= n_d; cur_q <= cur_d; la_q <= la_d; lv_q <= lv_d;
    lsel_q <= lsel_d; freed_q <= freed_d; reused_q <= reused_d; stop_q <= stop_d;
    full_q <= full_d; st_q <= st_d; ucnt_q <= ucnt_d;
    o_st_q <= o_st_d; o_bh_q <= o_bh_d; o_bs_q <= o_bs_d; o_wb_q <= o_wb_d; o_ru_q <= o_ru_d;
    o_full_q <= o_full_d; o_last_q <= o_last_d; o_uc_q <= o_uc_d; o_used_q <= o_used_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign res_valid_o       = res_valid_q;
  assign status_o          = o_st_q;
  assign block_handle_o    = o_bh_q;
  assign block_size_o      = o_bs_q;
  assign needs_writeback_o = o_wb_q;
  assign reuse_o           = o_ru_q;
  assign use_count_o       = o_uc_q;
  assign would_be_full_o   = o_full_q;
  assign used_bytes_o      = o_used_q;
  assign last_o            = o_last_q;

endmodule

[design/bllc_checker.sv]
// ----------------------------------------------------------------------------
// bllc_checker
// port level checks of the dual list lru block cache
// ----------------------------------------------------------------------------
module bllc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          res_valid_o,
  input logic [bllc_pkg::STAT_W-1:0]   status_o,
  input logic                          reuse_o,
  input logic                          last_o,
  input logic                          would_be_full_o,
  input logic [bllc_pkg::USED_W-1:0]   used_bytes_o
);
  import bllc_pkg::*;

  // accepted transaction keeps the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after accepted transaction");

  // results of one transaction come back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |=> res_valid_o)
    else $error("gap inside a result burst");

  // error results are single
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != ST_OK |-> last_o && !reuse_o)
    else $error("error result not final or marked reuse");

  // totals are the same on every result of a burst
  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |=> $stable(used_bytes_o) && $stable(would_be_full_o))
    else $error("totals changed within a burst");

endmodule

bind dual_list_lru_block_cache bllc_checker u_bllc_checker (.*);

[dv/tb_dual_list_lru_block_cache.sv]
// ----------------------------------------------------------------------------
// tb_dual_list_lru_block_cache
// self-checking bench for the dual list lru block cache: a behavioral model
// of both recency lists, counts and used bytes predicts every result of each
// accepted request; results are compared field by field in order. directed
// corner requests come first, then random traffic over a small handle pool
// under several capacity and free factor settings, with random idle bursts.
// ----------------------------------------------------------------------------
module tb_dual_list_lru_block_cache;
  import bllc_pkg::*;

  localparam int NE = ENTRIES_DEF;
  localparam logic [UCNT_W-1:0] CNT_MAX = '1;
  localparam logic [USED_W-1:0] USED_MAX = '1;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] bhandle;
    logic [SIZE_W-1:0]   bsize;
    logic                wb;
    logic                reuse;
    logic [UCNT_W-1:0]   ucnt;
    logic                full;
    logic [USED_W-1:0]   used;
    logic                last;
  } blk_result_t;

  class cache_scoreboard;
    blk_result_t         pending_q[$];
    int                  errors;
    int                  n_checked;
    bit                  vld[NE];
    logic [HANDLE_W-1:0] hnd[NE];
    logic [SIZE_W-1:0]   bsz[NE];
    bit                  onw[NE];
    logic [UCNT_W-1:0]   rc[NE];
    logic [UCNT_W-1:0]   wc[NE];
    int                  prv[NE];
    int                  nxt[NE];
    int                  hd[2];
    int                  tl[2];
    logic [USED_W-1:0]   used;
    logic [SIZE_W-1:0]   cap;
    logic [FACTOR_W-1:0] fac;

    function new();
      for (int i = 0; i < NE; i++) begin
        vld[i] = 0; prv[i] = -1; nxt[i] = -1;
      end
      hd = '{-1, -1}; tl = '{-1, -1};
      used = '0; cap = '0; fac = FACTOR_W'(1);
      errors = 0; n_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == CFG_CAPACITY) cap = d;
      else if (idx == CFG_FACTOR) fac = d[FACTOR_W-1:0];
    endfunction

    function int find(logic [HANDLE_W-1:0] h);
      for (int i = 0; i < NE; i++) if (vld[i] && hnd[i] == h) return i;
      return -1;
    endfunction

    function void unlink(int i);
      int l;
      int p;
      int n;
      l = onw[i]; p = prv[i]; n = nxt[i];
      if (p < 0) hd[l] = n; else nxt[p] = n;
      if (n < 0) tl[l] = p; else prv[n] = p;
      prv[i] = -1; nxt[i] = -1;
    endfunction

    function void append(int i, bit l);
      int t;
      t = tl[l];
      prv[i] = t; nxt[i] = -1;
      if (t < 0) hd[l] = i; else nxt[t] = i;
      tl[l] = i; onw[i] = l;
    endfunction

    function void used_sub(logic [SIZE_W-1:0] v);
      used = (used < v) ? '0 : used - v;
    endfunction

    function void used_add(logic [SIZE_W-1:0] v);
      logic [USED_W:0] s;
      s = used + v;
      used = (s > USED_MAX) ? USED_MAX : s[USED_W-1:0];
    endfunction

    function blk_result_t mk(logic [STAT_W-1:0] st);
      blk_result_t r;
      r = '0; r.status = st;
      return r;
    endfunction

    function void scan(bit l, logic [SIZE_W-1:0] size, ref blk_result_t out[$],
                       ref bit reused);
      longint unsigned thresh;
      longint unsigned freed;
      int cur;
      int nx;
      blk_result_t r;
      thresh = longint'(size) * fac;
      freed = 0;
      cur = hd[l];
      for (int g = 0; g < NE && cur >= 0 && out.size() < 64; g++) begin
        nx = nxt[cur];
        if (rc[cur] != 0 || wc[cur] != 0) begin
          cur = nx;
          continue;
        end
        unlink(cur);
        vld[cur] = 0;
        r = mk(ST_OK);
        r.bhandle = hnd[cur]; r.bsize = bsz[cur]; r.wb = l;
        r.reuse = !reused && bsz[cur] >= size;
        if (r.reuse) reused = 1;
        out.push_back(r);
        freed += bsz[cur];
        used_sub(bsz[cur]);
        if (freed >= thresh) break;
        cur = nx;
      end
    endfunction

    function void note(logic [FUNC_W-1:0] f, logic [HANDLE_W-1:0] h,
                       logic [SIZE_W-1:0] size, bit wm);
      blk_result_t out[$];
      int i;
      bit reused;
      bit full;
      i = find(h);
      case (f)
        FUNC_INSERT: begin
          if (i >= 0) begin
            unlink(i);
            used_sub(bsz[i]);
          end else begin
            for (int k = 0; k < NE; k++) if (!vld[k]) begin i = k; break; end
          end
          if (i < 0) out.push_back(mk(ST_FULL));
          else begin
            vld[i] = 1; hnd[i] = h; bsz[i] = size;
            rc[i] = wm ? UCNT_W'(0) : UCNT_W'(1); wc[i] = wm ? UCNT_W'(1) : UCNT_W'(0);
            append(i, wm);
            used_add(size);
            out.push_back(mk(ST_OK));
          end
        end
        FUNC_ACQUIRE, FUNC_RELEASE: begin
          if (i < 0) out.push_back(mk(ST_NOT_FOUND));
          else begin
            logic [UCNT_W-1:0] c;
            blk_result_t r;
            c = wm ? wc[i] : rc[i];
            if (f == FUNC_ACQUIRE) begin
              if (c < CNT_MAX) c++;
              if (wm) wc[i] = c; else rc[i] = c;
              if (onw[i] != wm || nxt[i] >= 0) begin
                unlink(i);
                append(i, wm);
              end
              r = mk(ST_OK); r.ucnt = c; out.push_back(r);
            end else if (c == 0) out.push_back(mk(ST_UNDERFLOW));
            else begin
              c--;
              if (wm) wc[i] = c; else rc[i] = c;
              r = mk(ST_OK); r.ucnt = c; out.push_back(r);
            end
          end
        end
        default: begin
          reused = 0;
          scan(0, size, out, reused);
          if (!reused) scan(1, size, out, reused);
          if (out.size() == 0) out.push_back(mk(ST_NONE));
        end
      endcase
      full = ({1'b0, used} + size) >= cap;
      foreach (out[k]) begin
        out[k].full = full; out[k].used = used;
        out[k].last = (k == out.size() - 1);
        pending_q.push_back(out[k]);
      end
    endfunction

    function void report(string what);
      $display("tb: mismatch %0d: %s", errors, what);
      errors++;
    endfunction

    function void check(blk_result_t got);
      blk_result_t e;
      n_checked++;
      if (pending_q.size() == 0) begin
        report("result with no pending transaction");
        return;
      end
      e = pending_q.pop_front();
      if (got !== e)
        report($sformatf("exp st%0d h%h s%h wb%b ru%b c%0d f%b u%h l%b got st%0d h%h s%h wb%b ru%b c%0d f%b u%h l%b",
          e.status, e.bhandle, e.bsize, e.wb, e.reuse, e.ucnt, e.full, e.used, e.last,
          got.status, got.bhandle, got.bsize, got.wb, got.reuse, got.ucnt, got.full,
          got.used, got.last));
    endfunction
  endclass

  logic                  clk_i = 0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [FUNC_W-1:0]     func_i;
  logic [HANDLE_W-1:0]   handle_i;
  logic [SIZE_W-1:0]     size_i;
  logic                  write_mode_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  res_valid_o;
  blk_result_t           res;

  dual_list_lru_block_cache uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .handle_i, .size_i, .write_mode_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .res_valid_o,
    .status_o(res.status), .block_handle_o(res.bhandle), .block_size_o(res.bsize),
    .needs_writeback_o(res.wb), .reuse_o(res.reuse), .use_count_o(res.ucnt),
    .would_be_full_o(res.full), .used_bytes_o(res.used), .last_o(res.last)
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  cache_scoreboard sb = new();
  logic [HANDLE_W-1:0] pool[40];
  bit idling = 1;
  int n_req = 0;

  always @(posedge clk_i) if (rst_ni === 1'b1 && res_valid_o === 1'b1) sb.check(res);

  task automatic idle_gap();
    if (idling && $urandom_range(0, 3) == 0) begin
      start_i <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic send_req(logic [FUNC_W-1:0] f, logic [HANDLE_W-1:0] h,
                          logic [SIZE_W-1:0] s, bit wm);
    idle_gap();
    start_i <= 1; func_i <= f; handle_i <= h; size_i <= s; write_mode_i <= wm;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note(f, h, s, wm);
    n_req++;
  endtask

  task automatic drain();
    start_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    drain();
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= d;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_reg(idx, d);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    if ($urandom_range(0, 9) == 0) return SIZE_W'({$urandom, $urandom});
    return $urandom_range(0, 4096);
  endfunction

  task automatic rand_req();
    logic [HANDLE_W-1:0] h;
    int pick;
    h = ($urandom_range(0, 19) == 0) ? HANDLE_W'({$urandom, $urandom})
                                      : pool[$urandom_range(0, 39)];
    pick = $urandom_range(0, 99);
    if (pick < 35) send_req(FUNC_INSERT, h, rand_size(), 1'($urandom));
    else if (pick < 60) send_req(FUNC_ACQUIRE, h, rand_size(), 1'($urandom));
    else if (pick < 85) send_req(FUNC_RELEASE, h, rand_size(), 1'($urandom));
    else send_req(FUNC_EVICT, h, rand_size(), 1'($urandom));
  endtask

  initial begin
    logic [HANDLE_W-1:0] hmax;
    logic [SIZE_W-1:0]   smax;
    hmax = '1; smax = '1;
    rst_ni <= 0; start_i <= 0; func_i <= FUNC_INSERT; handle_i <= '0; size_i <= '0;
    write_mode_i <= 0; cfg_valid_i <= 0; cfg_index_i <= CFG_CAPACITY; cfg_data_i <= '0;
    foreach (pool[i]) pool[i] = HANDLE_W'({$urandom, $urandom});
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed corners under reset settings, then under capacity 5000 and factor 0
    send_req(FUNC_EVICT, '0, 16, 1'b0);
    send_req(FUNC_RELEASE, 48'h5, 0, 1'b0);
    send_req(FUNC_ACQUIRE, 48'h5, 0, 1'b1);
    send_req(FUNC_INSERT, '0, '0, 1'b0);
    send_req(FUNC_INSERT, hmax, smax, 1'b1);
    send_req(FUNC_INSERT, 48'h1, smax, 1'b0);
    send_req(FUNC_INSERT, 48'h2, smax, 1'b1);
    send_req(FUNC_ACQUIRE, hmax, 0, 1'b0);
    send_req(FUNC_ACQUIRE, hmax, 0, 1'b1);
    send_req(FUNC_RELEASE, hmax, 0, 1'b0);
    send_req(FUNC_RELEASE, hmax, 0, 1'b0);
    send_req(FUNC_RELEASE, hmax, 0, 1'b1);
    send_req(FUNC_RELEASE, hmax, 0, 1'b1);
    send_req(FUNC_RELEASE, hmax, 0, 1'b1);
    send_req(FUNC_INSERT, 48'h1, 40'd100, 1'b1);
    send_req(FUNC_EVICT, '0, '0, 1'b0);
    send_req(FUNC_RELEASE, '0, 0, 1'b0);
    send_req(FUNC_RELEASE, 48'h1, 0, 1'b1);
    send_req(FUNC_RELEASE, 48'h2, 0, 1'b1);
    send_req(FUNC_EVICT, '0, smax, 1'b0);
    write_reg(CFG_CAPACITY, 40'd5000);
    write_reg(CFG_FACTOR, 5'd0);
    send_req(FUNC_EVICT, '0, 0, 1'b0);
    send_req(FUNC_INSERT, 48'h3, 40'd4999, 1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_CAPACITY, smax); write_reg(CFG_FACTOR, 5'd1); end
        1: begin write_reg(CFG_CAPACITY, 40'd20000); write_reg(CFG_FACTOR, 5'd16); end
        2: begin write_reg(CFG_CAPACITY, '0); write_reg(CFG_FACTOR, 5'd31); end
        3: begin
          write_reg(CFG_CAPACITY, $urandom_range(0, 1 << 17));
          write_reg(CFG_FACTOR, $urandom_range(1, 16));
        end
        default: begin
          write_reg(CFG_CAPACITY, CFG_DATA_W'({$urandom, $urandom}));
          write_reg(CFG_FACTOR, $urandom_range(1, 4));
          idling = 0;
        end
      endcase
      repeat (47) rand_req();
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("tb: %0d requests sent, %0d results checked over directed corners",
             n_req, sb.n_checked);
    $display("tb: and five random phases of capacity and free factor settings");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
